// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/slmph_pkg.sv =====
// Package: types, tables and codes of the segment level meter.
`timescale 1ns / 1ps
`default_nettype none
package slmph_pkg;

  localparam int SEG_COUNT = 8;

  typedef struct packed {
    logic [15:0] peak_magnitude;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic [15:0]        duty_0;
    logic [15:0]        duty_1;
    logic [15:0]        duty_2;
    logic [15:0]        duty_3;
    logic [15:0]        duty_4;
    logic [15:0]        duty_5;
    logic [15:0]        duty_6;
    logic [15:0]        duty_7;
    logic signed [11:0] bar_level;
    logic signed [3:0]  held_segment;
  } out_t;

  typedef enum logic [1:0] {
    CFG_FLOOR_LEVEL = 2'd0,
    CFG_DECAY_RATE  = 2'd1,
    CFG_HOLD_TIME   = 2'd2,
    CFG_FULL_DUTY   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [11:0] floor_level;
    logic [13:0]        decay_rate;
    logic [15:0]        hold_time;
    logic [15:0]        full_duty;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic fall_go;
    logic apply;
    logic raise;
    logic seg;
    logic part_go;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } sts_t;

  localparam logic [7:0]  DT_CAP      = 8'd250;
  localparam logic [22:0] FALL_ROUND  = 23'd500;
  // ceil(2^33 / 1000): exact quotient by 1000 for dividends below 2^23
  localparam logic [23:0] RECIP_MS    = 24'd8589935;
  localparam logic [10:0] OCTAVE_256  = 11'd1541;

  localparam logic signed [11:0] SEG_THRESH [SEG_COUNT] = '{
    -12'sd576, -12'sd480, -12'sd384, -12'sd288, -12'sd192, -12'sd96, -12'sd48, -12'sd8
  };
  localparam logic signed [11:0] SEG_TOP [SEG_COUNT] = '{
    -12'sd480, -12'sd384, -12'sd288, -12'sd192, -12'sd96, -12'sd48, -12'sd8, 12'sd0
  };
  localparam logic [9:0] SEG_SPAN [SEG_COUNT] = '{
    10'd96, 10'd96, 10'd96, 10'd96, 10'd96, 10'd48, 10'd40, 10'd8
  };

  localparam logic [10:0] LOG_TAB [17] = '{
    11'd0, 11'd135, 11'd262, 11'd382, 11'd496, 11'd605, 11'd708, 11'd807, 11'd902,
    11'd992, 11'd1080, 11'd1163, 11'd1244, 11'd1322, 11'd1398, 11'd1471, 11'd1541
  };

endpackage
`default_nettype wire

// ===== hw/rtl/slmph_div.sv =====
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
`timescale 1ns / 1ps
`default_nettype none
module slmph_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [22:0] dividend,
  input  wire logic [9:0]  divisor,
  output logic             busy,
  output logic             done,
  output logic [15:0]      quot
);
  logic [9:0]  rem_r, rem_nxt;
  logic [9:0]  dvs_r, dvs_nxt;
  logic [15:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [10:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[15]};
    if (start) begin
      rem_nxt = {3'd0, dividend[22:16]};
      q_nxt   = dividend[15:0];
      dvs_nxt = divisor;
      cnt_nxt = 5'd16;
    end else if (cnt_r != 5'd0) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 10'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[9:0];
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = 5'(cnt_r - 5'd1);
      if (cnt_r == 5'd1) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
    if (!rst_n) begin
      cnt_r  <= 5'd0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = (cnt_r != 5'd0);
  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

// ===== hw/rtl/slmph_dp.sv =====
// Datapath: ballistics, log conversion, peak hold and segment duties.
`timescale 1ns / 1ps
`default_nettype none
module slmph_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire slmph_pkg::cfg_t cfg,
  input  wire slmph_pkg::cmd_t cmd,
  input  wire slmph_pkg::in_t  in_item,
  output slmph_pkg::sts_t    sts,
  output slmph_pkg::out_t    result
);
  import slmph_pkg::*;

  logic [15:0]        p_r;
  logic [31:0]        now_r, prev_r, prev_nxt, armed_r, armed_nxt;
  logic               seen_r, seen_nxt;
  logic signed [11:0] level_r, level_nxt;
  logic signed [3:0]  peak_r, peak_nxt;
  logic [21:0]        fprod_r;
  logic [12:0]        fall_r;
  logic [3:0]         k_r, sh_r;
  logic [10:0]        r_r, v_r;
  logic [14:0]        oct_r;
  logic               big_r, zero_r;
  logic signed [3:0]  cur_r;
  logic               pfull_r;
  logic [22:0]        num_r;
  logic [9:0]         span_r;

  logic [31:0] dt_full;
  logic [7:0]  dt8;
  logic [22:0] fnum;
  logic [46:0] fmul;
  logic [3:0]  e;
  logic [15:0] m;
  logic [7:0]  tdiff;
  logic [19:0] lprod;
  logic signed [13:0] lv14, floor14;
  logic signed [15:0] db;
  logic [14:0] neg;
  logic [15:0] negr;
  logic signed [11:0] in_lv;
  logic signed [3:0]  cur;
  logic [2:0]  cidx;
  logic signed [12:0] ldiff;
  logic        pfull;
  logic [31:0] held_for;
  logic        div_start, div_busy, div_done;
  logic [22:0] div_a;
  logic [9:0]  div_b;
  logic [15:0] quot;
  logic [15:0] duty [SEG_COUNT];

  always_comb begin
    dt_full = now_r - prev_r;
    dt8 = (dt_full > {24'd0, DT_CAP}) ? DT_CAP : dt_full[7:0];
    fnum = {1'b0, fprod_r} + FALL_ROUND;
    fmul = {24'd0, fnum} * {23'd0, RECIP_MS};
    e = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (p_r[i]) e = 4'(i);
    end
    m = p_r << (4'd15 - e);
    tdiff = 8'(LOG_TAB[{1'b0, k_r} + 5'd1] - LOG_TAB[k_r]);
    lprod = ({12'd0, tdiff} * {9'd0, r_r}) + 20'd1024;
    db = $signed({5'd0, v_r}) - $signed({1'b0, oct_r});
    neg = 15'(-db);
    negr = {1'b0, neg} + 16'd8;
    if (big_r || db >= 0) in_lv = 12'sd0;
    else in_lv = 12'(-$signed({1'b0, negr[15:4]}));
    lv14 = $signed({{2{level_r[11]}}, level_r}) - $signed({1'b0, fall_r});
    floor14 = $signed({{2{cfg.floor_level[11]}}, cfg.floor_level});
    cur = -4'sd1;
    for (int i = 0; i < SEG_COUNT; i++) begin
      if (level_r >= SEG_THRESH[i]) cur = 4'(i);
    end
    cidx = cur[2:0];
    ldiff = $signed({level_r[11], level_r}) - $signed({SEG_THRESH[cidx][11], SEG_THRESH[cidx]});
    pfull = (level_r >= SEG_TOP[cidx]);
    held_for = now_r - armed_r;
  end

  always_comb begin
    level_nxt = level_r;
    prev_nxt  = prev_r;
    seen_nxt  = seen_r;
    peak_nxt  = peak_r;
    armed_nxt = armed_r;
    if (cmd.apply) begin
      if (seen_r) begin
        level_nxt = (lv14 < floor14) ? cfg.floor_level : lv14[11:0];
      end
      prev_nxt = now_r;
      seen_nxt = 1'b1;
    end
    if (cmd.raise && !zero_r && in_lv > level_r) begin
      level_nxt = in_lv;
    end
    if (cmd.seg) begin
      if (cur > peak_r) begin
        peak_nxt  = cur;
        armed_nxt = now_r;
      end else if (peak_r >= 0 && held_for >= {16'd0, cfg.hold_time}) begin
        peak_nxt  = cur;
        armed_nxt = now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      p_r   <= in_item.peak_magnitude;
      now_r <= in_item.time_ms;
    end
    if (cmd.prep) begin
      fprod_r <= {8'd0, cfg.decay_rate} * {14'd0, dt8};
      k_r     <= m[14:11];
      r_r     <= m[10:0];
      sh_r    <= 4'(4'd15 - e);
      big_r   <= p_r[15];
      zero_r  <= (p_r == 16'd0);
    end
    if (cmd.fall_go) begin
      fall_r <= fmul[45:33];
      v_r    <= 11'(LOG_TAB[k_r] + {2'd0, lprod[19:11]});
      oct_r  <= {11'd0, sh_r} * {4'd0, OCTAVE_256};
    end
    if (cmd.seg) begin
      cur_r   <= cur;
      pfull_r <= pfull;
      span_r  <= SEG_SPAN[cidx];
      num_r   <= (cur < 0 || pfull) ? 23'd0 :
                 ({7'd0, cfg.full_duty} * {16'd0, ldiff[6:0]});
    end
    if (!rst_n) begin
      level_r <= -12'sd960;
      peak_r  <= -4'sd1;
      armed_r <= 32'd0;
      prev_r  <= 32'd0;
      seen_r  <= 1'b0;
    end else begin
      level_r <= level_nxt;
      peak_r  <= peak_nxt;
      armed_r <= armed_nxt;
      prev_r  <= prev_nxt;
      seen_r  <= seen_nxt;
    end
  end

  assign div_start = cmd.part_go;
  assign div_a = num_r;
  assign div_b = span_r;

  slmph_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot)
  );

  always_comb begin
    for (int i = 0; i < SEG_COUNT; i++) begin
      if (cur_r > 4'(i) || (cur_r == 4'(i) && pfull_r)) duty[i] = cfg.full_duty;
      else if (cur_r == 4'(i)) duty[i] = quot;
      else duty[i] = 16'd0;
      if (peak_r == 4'(i)) duty[i] = cfg.full_duty;
    end
  end

  assign result.duty_0       = duty[0];
  assign result.duty_1       = duty[1];
  assign result.duty_2       = duty[2];
  assign result.duty_3       = duty[3];
  assign result.duty_4       = duty[4];
  assign result.duty_5       = duty[5];
  assign result.duty_6       = duty[6];
  assign result.duty_7       = duty[7];
  assign result.bar_level    = level_r;
  assign result.held_segment = peak_r;
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
endmodule
`default_nettype wire

// ===== hw/rtl/slmph_ctrl.sv =====
// Controller: sequences one item through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module slmph_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic            out_free,
  input  wire slmph_pkg::sts_t sts,
  output slmph_pkg::cmd_t      cmd,
  output logic                 idle,
  output logic                 load_out
);
  import slmph_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_PREP   = 8'b00000010,
    S_FGO    = 8'b00000100,
    S_APPLY  = 8'b00001000,
    S_RAISE  = 8'b00010000,
    S_SEG    = 8'b00100000,
    S_PWAIT  = 8'b01000000,
    S_FINISH = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = in_fire;
        if (in_fire) state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_FGO;
      end
      S_FGO: begin
        cmd.fall_go = 1'b1;
        state_nxt   = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_RAISE;
      end
      S_RAISE: begin
        cmd.raise = 1'b1;
        state_nxt = S_SEG;
      end
      S_SEG: begin
        cmd.seg   = 1'b1;
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        cmd.part_go = !sts.div_busy && !sts.div_done;
        if (sts.div_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        load_out = out_free;
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);
endmodule
`default_nettype wire

// ===== hw/rtl/segment_level_meter_peak_hold_top.sv =====
// Top level: eight-segment level meter with peak hold.
// One item is one meter tick and gives one result. An accepted item passes through five
// sequencing steps (the release fall by reciprocal multiplication included), the restoring
// divider for the interpolated duty of the bar-end segment, and a load of the output
// register; the next item is accepted only once the controller is back in idle.
// in_stall is low only while the controller is idle; the result sits in an output
// register, so a new item is taken while an earlier result waits for the consumer.
// A result still waiting when the next one is ready holds the controller until it leaves.
`timescale 1ns / 1ps
`default_nettype none
module segment_level_meter_peak_hold_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire slmph_pkg::in_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output slmph_pkg::out_t       out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data
);
  import slmph_pkg::*;

  `include "assert_macros.svh"

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  sts_t sts;
  out_t result, out_r;
  logic out_valid_r, out_valid_nxt;
  logic idle, load_out, in_fire, out_free;

  assign in_fire  = in_valid && idle;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !idle;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FLOOR_LEVEL: cfg_nxt.floor_level = cfg_data[11:0];
        CFG_DECAY_RATE:  cfg_nxt.decay_rate  = cfg_data[13:0];
        CFG_HOLD_TIME:   cfg_nxt.hold_time   = cfg_data;
        CFG_FULL_DUTY:   cfg_nxt.full_duty   = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
    out_valid_nxt = load_out ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (load_out) out_r <= result;
    if (!rst_n) begin
      cfg_r.floor_level <= -12'sd960;
      cfg_r.decay_rate  <= 14'd320;
      cfg_r.hold_time   <= 16'd1000;
      cfg_r.full_duty   <= 16'd65535;
      out_valid_r       <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  slmph_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle),
    .load_out (load_out)
  );

  slmph_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .cmd     (cmd),
    .in_item (in_data),
    .sts     (sts),
    .result  (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `ASSERT_ALWAYS(a_idle_div_quiet, clk, rst_n, !in_stall |-> !sts.div_busy)
  `ASSERT_ALWAYS(a_held_range, clk, rst_n,
    out_valid |-> (out_data.held_segment >= -4'sd1))
endmodule
`default_nettype wire
